// ===== hw/rtl/fost_pkg.sv =====
// ============================================================================
// fost_pkg - shared types and constants for the flow observer state tracker
// Holds controller states, command and status bundles, the flow entry
// layout, configuration register indexes and protocol constants.
// ============================================================================
package fost_pkg;

   // field widths fixed by the packet format
   localparam int SLOT_W   = 10;
   localparam int LEN_W    = 16;
   localparam int WORD_W   = 32;
   localparam int BYTE_W   = 8;
   localparam int STATE_W  = 3;
   localparam int TACT_W   = 2;
   localparam int CSR_IDX_W = 3;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SIG_MASK    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAGIC_VALUE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STOP_MASK   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_EXT_MASK    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE_TO     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ASSOC_TO    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_STOP_TO     = 3'd6;

   // reset values of the timeouts, 100 ms units
   localparam logic [BYTE_W-1:0] IDLE_TO_RST  = 8'd100;
   localparam logic [BYTE_W-1:0] ASSOC_TO_RST = 8'd30;
   localparam logic [BYTE_W-1:0] STOP_TO_RST  = 8'd20;

   // packet checks
   localparam logic [LEN_W-1:0]  MIN_LENGTH     = 16'd48;
   localparam logic [LEN_W-1:0]  EXT_MIN_LENGTH = 16'd51;
   localparam logic [BYTE_W-1:0] EXT_TYPE_HOP   = 8'd1;
   localparam logic [BYTE_W-1:0] EXT_II_MASK    = 8'h03;

   // opcodes
   localparam logic OP_PACKET = 1'b0;
   localparam logic OP_CLEAR  = 1'b1;

   // observer states as stored per flow
   localparam logic [STATE_W-1:0] FS_ZERO        = 3'd0;
   localparam logic [STATE_W-1:0] FS_UNIFLOW     = 3'd1;
   localparam logic [STATE_W-1:0] FS_ASSOCIATING = 3'd2;
   localparam logic [STATE_W-1:0] FS_ASSOCIATED  = 3'd3;
   localparam logic [STATE_W-1:0] FS_STOPWAIT    = 3'd4;
   localparam logic [STATE_W-1:0] FS_STOPPING    = 3'd5;

   // timer actions
   localparam logic [TACT_W-1:0] TA_NONE    = 2'd0;
   localparam logic [TACT_W-1:0] TA_START   = 2'd1;
   localparam logic [TACT_W-1:0] TA_REFRESH = 2'd2;

   typedef enum logic [1:0] {
      CTRL_SWEEP,
      CTRL_IDLE,
      CTRL_EXEC
   } ctrl_state_type;

   typedef struct packed {
      logic capture;
      logic execute;
      logic sweep;
   } ctrl_cmd_type;

   typedef struct packed {
      logic sweep_last;
   } ctrl_status_type;

   typedef struct packed {
      logic [WORD_W-1:0] sig_mask;
      logic [WORD_W-1:0] magic_value;
      logic [WORD_W-1:0] stop_mask;
      logic [WORD_W-1:0] extended_mask;
      logic [BYTE_W-1:0] idle_timeout;
      logic [BYTE_W-1:0] associated_timeout;
      logic [BYTE_W-1:0] stop_timeout;
   } cfg_type;

   typedef struct packed {
      logic [STATE_W-1:0] state;
      logic [WORD_W-1:0]  first_direction;
      logic [WORD_W-1:0]  associating_number;
      logic [WORD_W-1:0]  stopwait_number;
      logic [WORD_W-1:0]  packets;
   } entry_type;

endpackage

// ===== hw/rtl/fost_csr.sv =====
// ============================================================================
// fost_csr - configuration registers
// Plain write port; one register per index, unknown indexes are dropped.
// ============================================================================
module fost_csr
   import fost_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]    csr_wdata,
   output cfg_type              cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // decode the write
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SIG_MASK:    cfg_in.sig_mask           = csr_wdata;
            CSR_MAGIC_VALUE: cfg_in.magic_value        = csr_wdata;
            CSR_STOP_MASK:   cfg_in.stop_mask          = csr_wdata;
            CSR_EXT_MASK:    cfg_in.extended_mask      = csr_wdata;
            CSR_IDLE_TO:     cfg_in.idle_timeout       = csr_wdata[BYTE_W-1:0];
            CSR_ASSOC_TO:    cfg_in.associated_timeout = csr_wdata[BYTE_W-1:0];
            CSR_STOP_TO:     cfg_in.stop_timeout       = csr_wdata[BYTE_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   // hold the registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sig_mask           <= '0;
         cfg_ff.magic_value        <= '0;
         cfg_ff.stop_mask          <= '0;
         cfg_ff.extended_mask      <= '0;
         cfg_ff.idle_timeout       <= IDLE_TO_RST;
         cfg_ff.associated_timeout <= ASSOC_TO_RST;
         cfg_ff.stop_timeout       <= STOP_TO_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hw/rtl/fost_ctrl.sv =====
// ============================================================================
// fost_ctrl - sequencing controller
// Runs the valid-bit clearing sweep after reset, then takes one request at
// a time: capture and memory read, then execute and write back.
// ============================================================================
module fost_ctrl
   import fost_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  ctrl_status_type status,
   output ctrl_cmd_type    cmd,
   output logic            busy
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         CTRL_SWEEP: begin
            if (status.sweep_last) begin
               state_in = CTRL_IDLE;
            end
         end
         CTRL_IDLE: begin
            if (start) begin
               state_in = CTRL_EXEC;
            end
         end
         CTRL_EXEC: state_in = CTRL_IDLE;
         default:   state_in = CTRL_SWEEP;
      endcase
   end

   // commands to the datapath
   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      unique case (state_ff)
         CTRL_SWEEP: cmd.sweep = 1'b1;
         CTRL_IDLE: begin
            busy        = 1'b0;
            cmd.capture = start;
         end
         CTRL_EXEC: cmd.execute = 1'b1;
         default: begin
            cmd  = '0;
            busy = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTRL_SWEEP;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hw/rtl/fost_dpath.sv =====
// ============================================================================
// fost_dpath - flow table datapath
// Holds the request, the flow entry memory and its valid memory, steps the
// observer state of one flow and registers the response.
// ============================================================================
module fost_dpath
   import fost_pkg::*;
#(
   parameter int FLOW_SLOTS = 1024
)
(
   input  logic               clock,
   input  logic               reset,
   input  ctrl_cmd_type       cmd,
   output ctrl_status_type    status,
   input  cfg_type            cfg,
   input  logic               req_opcode,
   input  logic [SLOT_W-1:0]  req_flow_slot,
   input  logic [LEN_W-1:0]   req_packet_length,
   input  logic [WORD_W-1:0]  req_header_word,
   input  logic [WORD_W-1:0]  req_source_address,
   input  logic [WORD_W-1:0]  req_sequence_number,
   input  logic [WORD_W-1:0]  req_echo_number,
   input  logic [BYTE_W-1:0]  req_ext_type,
   input  logic [BYTE_W-1:0]  req_ext_len_ii,
   input  logic [BYTE_W-1:0]  req_hop_count_in,
   output logic               rsp_valid,
   output logic               rsp_processed,
   output logic               rsp_new_flow,
   output logic [STATE_W-1:0] rsp_flow_state,
   output logic [TACT_W-1:0]  rsp_timer_action,
   output logic [BYTE_W-1:0]  rsp_timer_value,
   output logic [BYTE_W-1:0]  rsp_hop_count_out,
   output logic               rsp_hop_count_updated,
   output logic [WORD_W-1:0]  rsp_flow_packets
);

   localparam int AW = (FLOW_SLOTS > 2) ? $clog2(FLOW_SLOTS) : 1;
   localparam int SW = (AW > SLOT_W) ? AW : SLOT_W;

   // memories
   logic      valid_mem [FLOW_SLOTS];
   entry_type entry_mem [FLOW_SLOTS];

   // captured request
   logic              opcode_ff;
   logic              in_range_ff;
   logic [AW-1:0]     idx_ff;
   logic [LEN_W-1:0]  length_ff;
   logic [WORD_W-1:0] flags_ff;
   logic [WORD_W-1:0] src_ff;
   logic [WORD_W-1:0] psn_ff;
   logic [WORD_W-1:0] pse_ff;
   logic [BYTE_W-1:0] ext_type_ff;
   logic [BYTE_W-1:0] len_ii_ff;
   logic [BYTE_W-1:0] hop_in_ff;

   // registered memory read data
   logic      rd_valid_ff;
   entry_type rd_entry_ff;

   // clearing sweep
   logic [AW-1:0] sweep_cnt_ff;
   logic [AW-1:0] sweep_cnt_in;

   // response registers
   logic               rsp_valid_ff;
   logic               rsp_processed_ff;
   logic               rsp_new_flow_ff;
   logic [STATE_W-1:0] rsp_flow_state_ff;
   logic [TACT_W-1:0]  rsp_timer_action_ff;
   logic [BYTE_W-1:0]  rsp_timer_value_ff;
   logic [BYTE_W-1:0]  rsp_hop_count_out_ff;
   logic               rsp_hop_count_updated_ff;
   logic [WORD_W-1:0]  rsp_flow_packets_ff;

   // read address from the request port
   logic [SW-1:0] slot_wide;
   logic [AW-1:0] rd_idx;
   logic          in_range;

   // execute-stage results
   logic               passed;
   logic               stop_flag;
   logic               serial_after;
   logic [WORD_W-1:0]  serial_diff;
   logic [STATE_W-1:0] cur_state;
   logic [WORD_W-1:0]  cur_packets;
   entry_type          entry_next;
   logic [TACT_W-1:0]  tact;
   logic [BYTE_W-1:0]  tval;
   logic [BYTE_W-1:0]  hop_out;
   logic               hop_upd;
   logic               entry_we;
   logic               valid_we;
   logic               valid_wdata;
   logic [AW-1:0]      valid_waddr;

   assign slot_wide = SW'(req_flow_slot);
   assign rd_idx    = slot_wide[AW-1:0];
   assign in_range  = 32'(req_flow_slot) < FLOW_SLOTS;

   // capture the request
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         opcode_ff   <= req_opcode;
         in_range_ff <= in_range;
         idx_ff      <= rd_idx;
         length_ff   <= req_packet_length;
         flags_ff    <= req_header_word;
         src_ff      <= req_source_address;
         psn_ff      <= req_sequence_number;
         pse_ff      <= req_echo_number;
         ext_type_ff <= req_ext_type;
         len_ii_ff   <= req_ext_len_ii;
         hop_in_ff   <= req_hop_count_in;
      end
   end

   // advance the sweep counter
   assign sweep_cnt_in      = cmd.sweep ? sweep_cnt_ff + 1'b1 : sweep_cnt_ff;
   assign status.sweep_last = (sweep_cnt_ff == AW'(FLOW_SLOTS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_cnt_ff <= '0;
      end else begin
         sweep_cnt_ff <= sweep_cnt_in;
      end
   end

   // step the flow entry
   always_comb begin
      stop_flag   = (flags_ff & cfg.stop_mask) != '0;
      passed      = in_range_ff && (length_ff >= MIN_LENGTH) &&
                    ((flags_ff & cfg.sig_mask) == cfg.magic_value);
      cur_state   = rd_valid_ff ? rd_entry_ff.state : FS_ZERO;
      cur_packets = rd_valid_ff ? rd_entry_ff.packets : '0;
      serial_diff = pse_ff - rd_entry_ff.associating_number;
      serial_after = (serial_diff != '0) && !serial_diff[WORD_W-1];

      entry_next         = rd_entry_ff;
      entry_next.packets = cur_packets + 1'b1;
      entry_next.state   = cur_state;
      tact               = TA_NONE;
      tval               = '0;

      case (cur_state)
         FS_ZERO: begin
            entry_next.state           = FS_UNIFLOW;
            entry_next.first_direction = src_ff;
            tact                       = TA_START;
            tval                       = cfg.idle_timeout;
         end
         FS_UNIFLOW: begin
            tact = TA_REFRESH;
            tval = cfg.idle_timeout;
            if (rd_entry_ff.first_direction != src_ff) begin
               entry_next.state              = FS_ASSOCIATING;
               entry_next.associating_number = psn_ff;
            end
         end
         FS_ASSOCIATING: begin
            tact = TA_REFRESH;
            tval = cfg.idle_timeout;
            if (rd_entry_ff.first_direction == src_ff && serial_after) begin
               entry_next.state = FS_ASSOCIATED;
            end
         end
         FS_ASSOCIATED: begin
            tact = TA_REFRESH;
            tval = cfg.associated_timeout;
            if (stop_flag) begin
               entry_next.state           = FS_STOPWAIT;
               entry_next.first_direction = src_ff;
               entry_next.stopwait_number = psn_ff;
            end
         end
         FS_STOPWAIT: begin
            tact = TA_REFRESH;
            tval = cfg.associated_timeout;
            if (stop_flag && rd_entry_ff.first_direction != src_ff &&
                rd_entry_ff.stopwait_number == pse_ff) begin
               entry_next.state = FS_STOPPING;
               tval             = cfg.stop_timeout;
            end
         end
         default: begin
            tact = TA_NONE;
            tval = '0;
         end
      endcase

      // extended header hop count
      hop_upd = ((flags_ff & cfg.extended_mask) != '0) && (length_ff >= EXT_MIN_LENGTH) &&
                (ext_type_ff == EXT_TYPE_HOP) && ((len_ii_ff & EXT_II_MASK) == '0);
      hop_out = hop_upd ? hop_in_ff + 1'b1 : hop_in_ff;
   end

   // write enables for the two memories
   always_comb begin
      entry_we    = cmd.execute && (opcode_ff == OP_PACKET) && passed;
      valid_we    = 1'b0;
      valid_wdata = 1'b0;
      valid_waddr = idx_ff;
      if (cmd.sweep) begin
         valid_we    = 1'b1;
         valid_waddr = sweep_cnt_ff;
      end else if (cmd.execute && opcode_ff == OP_CLEAR && in_range_ff) begin
         valid_we = 1'b1;
      end else if (entry_we) begin
         valid_we    = 1'b1;
         valid_wdata = 1'b1;
      end
   end

   // flow entry memory
   always_ff @(posedge clock) begin
      if (entry_we) begin
         entry_mem[idx_ff] <= entry_next;
      end
      if (cmd.capture) begin
         rd_entry_ff <= entry_mem[rd_idx];
      end
   end

   // valid memory, cleared by the sweep after reset
   always_ff @(posedge clock) begin
      if (valid_we) begin
         valid_mem[valid_waddr] <= valid_wdata;
      end
      if (cmd.capture) begin
         rd_valid_ff <= valid_mem[rd_idx];
      end
   end

   // register the response
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.execute;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         rsp_processed_ff         <= 1'b0;
         rsp_new_flow_ff          <= 1'b0;
         rsp_flow_state_ff        <= FS_ZERO;
         rsp_timer_action_ff      <= TA_NONE;
         rsp_timer_value_ff       <= '0;
         rsp_hop_count_out_ff     <= '0;
         rsp_hop_count_updated_ff <= 1'b0;
         rsp_flow_packets_ff      <= '0;
         if (opcode_ff == OP_PACKET) begin
            rsp_hop_count_out_ff <= hop_in_ff;
            if (passed) begin
               rsp_processed_ff         <= 1'b1;
               rsp_new_flow_ff          <= !rd_valid_ff;
               rsp_flow_state_ff        <= entry_next.state;
               rsp_timer_action_ff      <= tact;
               rsp_timer_value_ff       <= tval;
               rsp_hop_count_out_ff     <= hop_out;
               rsp_hop_count_updated_ff <= hop_upd;
               rsp_flow_packets_ff      <= entry_next.packets;
            end
         end
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_processed         = rsp_processed_ff;
   assign rsp_new_flow          = rsp_new_flow_ff;
   assign rsp_flow_state        = rsp_flow_state_ff;
   assign rsp_timer_action      = rsp_timer_action_ff;
   assign rsp_timer_value       = rsp_timer_value_ff;
   assign rsp_hop_count_out     = rsp_hop_count_out_ff;
   assign rsp_hop_count_updated = rsp_hop_count_updated_ff;
   assign rsp_flow_packets      = rsp_flow_packets_ff;

endmodule

// ===== hw/rtl/flow_observer_state_tracker_top.sv =====
// ============================================================================
// flow_observer_state_tracker_top - per-packet flow observer
// Checks each packet, keeps a per-slot observer state, packet count and
// serial numbers, and reports timer actions and hop count updates.
//
//   channel   ports                          handshake
//   --------  -----------------------------  ------------------------------
//   request   start, busy, req_*             taken when start & !busy
//   response  rsp_valid, rsp_*               one-cycle strobe, no back-pressure
//   config    csr_we, csr_index, csr_wdata   written when csr_we, no wait
//
// A request runs in two steps: the capture edge reads the flow entry and its
// valid bit from memory, the next edge writes the entry back and loads the
// response, which shows in the cycle after. busy is high for a single cycle
// per request, so a new request is taken only once the last is written back.
// After reset the valid memory is cleared one slot a cycle while busy stays
// high. The response cannot be stalled; configuration is taken at any time.
// ============================================================================
module flow_observer_state_tracker_top
   import fost_pkg::*;
#(
   parameter int FLOW_SLOTS = 1024
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_opcode,
   input  logic [SLOT_W-1:0]    req_flow_slot,
   input  logic [LEN_W-1:0]     req_packet_length,
   input  logic [WORD_W-1:0]    req_header_word,
   input  logic [WORD_W-1:0]    req_source_address,
   input  logic [WORD_W-1:0]    req_sequence_number,
   input  logic [WORD_W-1:0]    req_echo_number,
   input  logic [BYTE_W-1:0]    req_ext_type,
   input  logic [BYTE_W-1:0]    req_ext_len_ii,
   input  logic [BYTE_W-1:0]    req_hop_count_in,
   output logic                 rsp_valid,
   output logic                 rsp_processed,
   output logic                 rsp_new_flow,
   output logic [STATE_W-1:0]   rsp_flow_state,
   output logic [TACT_W-1:0]    rsp_timer_action,
   output logic [BYTE_W-1:0]    rsp_timer_value,
   output logic [BYTE_W-1:0]    rsp_hop_count_out,
   output logic                 rsp_hop_count_updated,
   output logic [WORD_W-1:0]    rsp_flow_packets,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]    csr_wdata
);

   cfg_type         cfg;
   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   fost_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   fost_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   fost_dpath #(
      .FLOW_SLOTS (FLOW_SLOTS)
   ) u_dpath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .cfg                   (cfg),
      .req_opcode            (req_opcode),
      .req_flow_slot         (req_flow_slot),
      .req_packet_length     (req_packet_length),
      .req_header_word       (req_header_word),
      .req_source_address    (req_source_address),
      .req_sequence_number   (req_sequence_number),
      .req_echo_number       (req_echo_number),
      .req_ext_type          (req_ext_type),
      .req_ext_len_ii        (req_ext_len_ii),
      .req_hop_count_in      (req_hop_count_in),
      .rsp_valid             (rsp_valid),
      .rsp_processed         (rsp_processed),
      .rsp_new_flow          (rsp_new_flow),
      .rsp_flow_state        (rsp_flow_state),
      .rsp_timer_action      (rsp_timer_action),
      .rsp_timer_value       (rsp_timer_value),
      .rsp_hop_count_out     (rsp_hop_count_out),
      .rsp_hop_count_updated (rsp_hop_count_updated),
      .rsp_flow_packets      (rsp_flow_packets)
   );

   // every accepted request is answered by a response
   a_rsp_follows_req: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_valid)
      else $error("response missing two cycles after request");

   // no response without an earlier accepted request
   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !$past(reset, 2)) |-> $past(start && !busy, 2))
      else $error("response without request");

   // a rejected packet or clear reports no flow activity
   a_reject_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_processed) |->
         (!rsp_new_flow && rsp_timer_action == TA_NONE && rsp_flow_packets == '0))
      else $error("flow activity on an unprocessed request");

   // a new flow always starts its timer in uniflow with one packet
   a_new_flow_start: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_new_flow) |->
         (rsp_timer_action == TA_START && rsp_flow_state == FS_UNIFLOW &&
          rsp_flow_packets == 32'd1))
      else $error("new flow without timer start");

endmodule
